// ===== design/irdc_pkg.sv =====
// shared types, widths and breakpoint curves for the ir distance curve interpolator
`default_nettype none

package irdc_pkg;

  localparam int unsigned DIST_W         = 10;
  localparam int unsigned MV_W           = 12;
  localparam int unsigned MODEL_W        = 2;
  localparam int unsigned CURVE_COUNT    = 3;
  localparam int unsigned CURVE_SLOTS    = 14;
  localparam int unsigned SEGS           = CURVE_SLOTS - 1;
  localparam int unsigned SLOT_W         = $clog2(CURVE_SLOTS);
  localparam int unsigned LEN_W          = $clog2(CURVE_SLOTS + 1);
  localparam int unsigned NUM_W          = 21;
  localparam int unsigned DEN_W          = DIST_W;
  localparam int unsigned Q_W            = MV_W;
  localparam int unsigned BITS_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES     = Q_W / BITS_PER_STAGE;
  localparam int unsigned CMP_W          = DEN_W + Q_W;

  typedef logic [DIST_W-1:0] dist_tbl_t [CURVE_COUNT][CURVE_SLOTS];
  typedef logic [MV_W-1:0]   mv_tbl_t   [CURVE_COUNT][CURVE_SLOTS];
  typedef logic [LEN_W-1:0]  len_tbl_t  [CURVE_COUNT];

  localparam len_tbl_t CURVE_LEN = '{4'd14, 4'd12, 4'd12};

  localparam dist_tbl_t CURVE_DIST = '{
    '{10'd0, 10'd2, 10'd3, 10'd4, 10'd6, 10'd9, 10'd10, 10'd16, 10'd20, 10'd30,
      10'd45, 10'd50, 10'd80, 10'd600},
    '{10'd0, 10'd10, 10'd15, 10'd40, 10'd50, 10'd60, 10'd70, 10'd90, 10'd120,
      10'd140, 10'd150, 10'd600, 10'd0, 10'd0},
    '{10'd0, 10'd10, 10'd37, 10'd55, 10'd73, 10'd100, 10'd150, 10'd195, 10'd300,
      10'd450, 10'd550, 10'd600, 10'd0, 10'd0}
  };

  localparam mv_tbl_t CURVE_MV = '{
    '{12'd0, 12'd1120, 12'd720, 12'd1920, 12'd1790, 12'd2580, 12'd2600, 12'd1650,
      12'd1130, 12'd980, 12'd680, 12'd620, 12'd420, 12'd0},
    '{12'd0, 12'd2300, 12'd2750, 12'd1550, 12'd1250, 12'd1050, 12'd900, 12'd720,
      12'd550, 12'd480, 12'd450, 12'd0, 12'd0, 12'd0},
    '{12'd0, 12'd1550, 12'd3000, 12'd3080, 12'd3000, 12'd2500, 12'd2050, 12'd1800,
      12'd1560, 12'd1420, 12'd1390, 12'd1370, 12'd0, 12'd0}
  };

  typedef struct packed {
    logic [DIST_W-1:0] pos;
    logic [DIST_W-1:0] d0;
    logic [DIST_W-1:0] d1;
    logic [MV_W-1:0]   v0;
    logic [MV_W-1:0]   v1;
  } seg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } frac_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } div_t;

endpackage

`default_nettype wire

// ===== design/irdc_seg_find.sv =====
// two stages: breakpoint compares, then segment pick and endpoint fetch
`default_nettype none

module irdc_seg_find
  import irdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 14,
  parameter int unsigned DIST_LIMIT = 600
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [DIST_W-1:0]  dist_i,
  input  wire logic [MODEL_W-1:0] model_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      seg_t               seg_o
);

  localparam logic [DIST_W-1:0] DistLimit = DIST_W'(DIST_LIMIT);

  logic               a_valid_q;
  logic [DIST_W-1:0]  a_dist_q;
  logic [MODEL_W-1:0] a_model_q;
  logic [SEGS-1:0]    a_hit_q, a_hit_d;
  logic               b_valid_q;
  seg_t               b_seg_q, b_seg_d;
  logic               a_ready, b_ready;
  logic [MODEL_W-1:0] in_model;
  logic               in_ok;

  assign b_ready = !b_valid_q || out_ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  // curve select guarded against the unused code
  assign in_ok    = (32'(model_i) < CURVE_COUNT) && (dist_i != '0) && (dist_i < DistLimit);
  assign in_model = (32'(model_i) < CURVE_COUNT) ? model_i : '0;

  always_comb begin
    for (int i = 0; i < SEGS; i++) begin
      a_hit_d[i] = in_ok
                   && (32'(i + 1) < 32'(CURVE_LEN[in_model]))
                   && (32'(i + 1) < MAX_POINTS)
                   && (dist_i >= CURVE_DIST[in_model][i])
                   && (dist_i < CURVE_DIST[in_model][i+1]);
    end
  end

  // first matching segment wins
  always_comb begin
    logic [SLOT_W-1:0]  idx;
    logic [SLOT_W-1:0]  idx_n;
    logic [MODEL_W-1:0] m;
    idx = '0;
    for (int i = SEGS - 1; i >= 0; i--) begin
      if (a_hit_q[i]) begin
        idx = SLOT_W'(i);
      end
    end
    idx_n = idx + 1'b1;
    m = (32'(a_model_q) < CURVE_COUNT) ? a_model_q : '0;
    if (|a_hit_q) begin
      b_seg_d.pos = a_dist_q;
      b_seg_d.d0  = CURVE_DIST[m][idx];
      b_seg_d.d1  = CURVE_DIST[m][idx_n];
      b_seg_d.v0  = CURVE_MV[m][idx];
      b_seg_d.v1  = CURVE_MV[m][idx_n];
    end else begin
      // no segment: zero numerator over unit span
      b_seg_d.pos = '0;
      b_seg_d.d0  = '0;
      b_seg_d.d1  = DIST_W'(1);
      b_seg_d.v0  = '0;
      b_seg_d.v1  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_dist_q  <= dist_i;
      a_model_q <= model_i;
      a_hit_q   <= a_hit_d;
    end
    if (b_ready && a_valid_q) begin
      b_seg_q <= b_seg_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign seg_o       = b_seg_q;

endmodule

`default_nettype wire

// ===== design/irdc_num_calc.sv =====
// two stages: weighted products and span, then numerator sum
`default_nettype none

module irdc_num_calc
  import irdc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output      logic  in_ready_o,
  input  wire seg_t  seg_i,
  output      logic  out_valid_o,
  input  wire logic  out_ready_i,
  output      frac_t frac_o
);

  localparam int unsigned PROD_W = MV_W + DIST_W;

  logic              c_valid_q;
  logic [PROD_W-1:0] c_p0_q, c_p1_q;
  logic [DEN_W-1:0]  c_den_q;
  logic              d_valid_q;
  frac_t             d_frac_q;
  logic              c_ready, d_ready;
  logic [DIST_W-1:0] span_hi, span_lo;
  logic [PROD_W-1:0] sum;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  assign span_hi = seg_i.d1 - seg_i.pos;
  assign span_lo = seg_i.pos - seg_i.d0;
  assign sum     = c_p0_q + c_p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) c_valid_q <= in_valid_i;
      if (d_ready) d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_p0_q  <= PROD_W'(seg_i.v0) * PROD_W'(span_hi);
      c_p1_q  <= PROD_W'(seg_i.v1) * PROD_W'(span_lo);
      c_den_q <= seg_i.d1 - seg_i.d0;
    end
    if (d_ready && c_valid_q) begin
      d_frac_q.num <= sum[NUM_W-1:0];
      d_frac_q.den <= c_den_q;
    end
  end

  assign out_valid_o = d_valid_q;
  assign frac_o      = d_frac_q;

endmodule

`default_nettype wire

// ===== design/irdc_divider.sv =====
// pipelined restoring divider, three quotient bits per stage
`default_nettype none

module irdc_divider
  import irdc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire frac_t          frac_i,
  output      logic           out_valid_o,
  input  wire logic           out_ready_i,
  output      logic [Q_W-1:0] quo_o
);

  logic                  valid_q   [DIV_STAGES];
  logic                  ready     [DIV_STAGES];
  logic                  src_valid [DIV_STAGES];
  div_t                  stage_q [DIV_STAGES];
  div_t                  stage_d [DIV_STAGES];
  div_t                  src     [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src[s]       = '{rem: frac_i.num, den: frac_i.den, quo: '0};
      assign src_valid[s] = in_valid_i;
    end else begin : g_next
      assign src[s]       = stage_q[s-1];
      assign src_valid[s] = valid_q[s-1];
    end

    if (s == DIV_STAGES - 1) begin : g_last
      assign ready[s] = !valid_q[s] || out_ready_i;
    end else begin : g_mid
      assign ready[s] = !valid_q[s] || ready[s+1];
    end

    always_comb begin
      logic [CMP_W-1:0] rem;
      logic [CMP_W-1:0] shifted;
      int unsigned      b;
      stage_d[s] = src[s];
      rem = CMP_W'(src[s].rem);
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        b = Q_W - 1 - s * BITS_PER_STAGE - j;
        shifted = CMP_W'(src[s].den) << b;
        if (rem >= shifted) begin
          rem = rem - shifted;
          stage_d[s].quo[b] = 1'b1;
        end
      end
      stage_d[s].rem = rem[NUM_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (ready[s]) begin
        valid_q[s] <= src_valid[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[s] && src_valid[s]) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[DIV_STAGES-1];
  assign quo_o       = stage_q[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// ===== design/ir_distance_curve_interp.sv =====
// from input transfer to result: segment search, numerator, then divide, all registered
// throughput: one distance per cycle without output stall; stages stall only when full
// the 12-bit quotient is resolved 3 bits per divider stage, which sets the divider depth
// reset: rst_ni clears all stage valid bits and returns the sensor model select to 0
// top level: ir distance sensor voltage by piecewise linear interpolation
`default_nettype none

module ir_distance_curve_interp
  import irdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 14,
  parameter int unsigned DIST_LIMIT = 600
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [MODEL_W-1:0] cfg_wdata_i,    // sensor_model
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,   // [9:0] distance_cm
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [15:0]        m_axis_tdata    // [11:0] voltage_mv
);

  logic [MODEL_W-1:0] sensor_model_q;
  logic               seg_valid, seg_ready;
  seg_t               seg;
  logic               frac_valid, frac_ready;
  frac_t              frac;
  logic [Q_W-1:0]     quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_model_q <= '0;
    end else if (cfg_we_i) begin
      sensor_model_q <= cfg_wdata_i;
    end
  end

  irdc_seg_find #(
    .MAX_POINTS (MAX_POINTS),
    .DIST_LIMIT (DIST_LIMIT)
  ) u_seg_find (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .dist_i      (s_axis_tdata[DIST_W-1:0]),
    .model_i     (sensor_model_q),
    .out_valid_o (seg_valid),
    .out_ready_i (seg_ready),
    .seg_o       (seg)
  );

  irdc_num_calc u_num_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_valid),
    .in_ready_o  (seg_ready),
    .seg_i       (seg),
    .out_valid_o (frac_valid),
    .out_ready_i (frac_ready),
    .frac_o      (frac)
  );

  irdc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frac_valid),
    .in_ready_o  (frac_ready),
    .frac_i      (frac),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .quo_o       (quo)
  );

  assign m_axis_tdata = {(16 - Q_W)'(0), quo};

endmodule

`default_nettype wire

// ===== test/irdc_voltage_checker.sv =====
// checker for the ir distance curve interpolator: predicts each voltage and compares results
`default_nettype none

module irdc_voltage_checker
  import irdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 14,
  parameter int unsigned DIST_LIMIT = 600
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [MODEL_W-1:0] cfg_wdata_i,
  input  wire logic               s_tvalid_i,
  input  wire logic               s_tready_i,
  input  wire logic [15:0]        s_tdata_i,
  input  wire logic               m_tvalid_i,
  input  wire logic               m_tready_i,
  input  wire logic [15:0]        m_tdata_i,
  output      int                 mismatch_count_o,
  output      int                 pending_o
);

  localparam int unsigned SLOTS = 14;

  logic [9:0]         knee_cm [0:3*SLOTS-1];
  logic [11:0]        knee_mv [0:3*SLOTS-1];
  int unsigned        curve_pts [0:2];
  logic [MODEL_W-1:0] model_sel;
  logic [15:0]        voltage_due [$];

  initial begin
    knee_cm = '{10'd0, 10'd2, 10'd3, 10'd4, 10'd6, 10'd9, 10'd10, 10'd16, 10'd20, 10'd30,
                10'd45, 10'd50, 10'd80, 10'd600,
                10'd0, 10'd10, 10'd15, 10'd40, 10'd50, 10'd60, 10'd70, 10'd90, 10'd120,
                10'd140, 10'd150, 10'd600, 10'd0, 10'd0,
                10'd0, 10'd10, 10'd37, 10'd55, 10'd73, 10'd100, 10'd150, 10'd195, 10'd300,
                10'd450, 10'd550, 10'd600, 10'd0, 10'd0};
    knee_mv = '{12'd0, 12'd1120, 12'd720, 12'd1920, 12'd1790, 12'd2580, 12'd2600,
                12'd1650, 12'd1130, 12'd980, 12'd680, 12'd620, 12'd420, 12'd0,
                12'd0, 12'd2300, 12'd2750, 12'd1550, 12'd1250, 12'd1050, 12'd900,
                12'd720, 12'd550, 12'd480, 12'd450, 12'd0, 12'd0, 12'd0,
                12'd0, 12'd1550, 12'd3000, 12'd3080, 12'd3000, 12'd2500, 12'd2050,
                12'd1800, 12'd1560, 12'd1420, 12'd1390, 12'd1370, 12'd0, 12'd0};
    curve_pts = '{14, 12, 12};
  end

  function automatic logic [11:0] voltage_at(logic [MODEL_W-1:0] model, logic [9:0] d);
    int unsigned pts;
    int unsigned base;
    int unsigned lo;
    int unsigned hi;
    int unsigned num;
    int unsigned k;
    bit          found;
    voltage_at = '0;
    found = 1'b0;
    if (model < CURVE_COUNT && d != 0 && d < DIST_LIMIT) begin
      pts = curve_pts[model];
      if (pts > MAX_POINTS) pts = MAX_POINTS;
      if (pts > SLOTS) pts = SLOTS;
      base = model * SLOTS;
      for (k = 0; k + 1 < pts; k++) begin
        lo = knee_cm[base+k];
        hi = knee_cm[base+k+1];
        if (!found && d >= lo && d < hi) begin
          num = knee_mv[base+k] * (hi - d) + knee_mv[base+k+1] * (d - lo);
          voltage_at = 12'(num / (hi - lo));
          found = 1'b1;
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      model_sel <= '0;
      voltage_due.delete();
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) model_sel <= cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) voltage_due.push_back({4'b0, voltage_at(model_sel, s_tdata_i[9:0])});
      if (m_tvalid_i && m_tready_i) begin
        if (voltage_due.size() == 0) begin
          $display("%0t unexpected result transfer: expected none actual %0d", $time,
                   m_tdata_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = voltage_due.pop_front();
          if (m_tdata_i !== want) begin
            $display("%0t voltage_mv mismatch: expected %0d actual %0d", $time, want,
                     m_tdata_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      pending_o <= voltage_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_ir_distance_curve_interp.sv =====
// testbench top for the ir distance curve interpolator: stimulus, flow control and verdict
`default_nettype none

module tb_ir_distance_curve_interp;
  import irdc_pkg::*;

  localparam int unsigned MAX_PTS    = 14;
  localparam int unsigned DIST_LIM   = 600;
  localparam int unsigned LATENCY    = 8;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          RAND_ITEMS = 1750;
  localparam int          PHASES     = 8;

  localparam logic [MODEL_W-1:0] MODEL_SHORT  = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_MEDIUM = 2'd1;
  localparam logic [MODEL_W-1:0] MODEL_LONG   = 2'd2;
  localparam logic [MODEL_W-1:0] MODEL_UNUSED = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [MODEL_W-1:0] cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [15:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  int                 mismatch_count;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 cycles = 0;

  ir_distance_curve_interp #(.MAX_POINTS(MAX_PTS), .DIST_LIMIT(DIST_LIM)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  irdc_voltage_checker #(.MAX_POINTS(MAX_PTS), .DIST_LIMIT(DIST_LIM)) checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_distance(input logic [9:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // drain everything in flight, then write the sensor model
  task automatic set_model(input logic [MODEL_W-1:0] model);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= model;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [9:0] pick_distance();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) pick_distance = 10'($urandom_range(1, DIST_LIM - 1));
    else if (roll < 8) pick_distance = 10'($urandom_range(1, 160));
    else if (roll == 8) pick_distance = 10'($urandom_range(0, 1023));
    else begin
      case ($urandom_range(0, 5))
        0: pick_distance = 10'd0;
        1: pick_distance = 10'd1;
        2: pick_distance = 10'(DIST_LIM - 1);
        3: pick_distance = 10'(DIST_LIM);
        4: pick_distance = 10'd1023;
        default: pick_distance = 10'($urandom_range(DIST_LIM - 10, DIST_LIM + 10));
      endcase
    end
  endfunction

  initial begin
    logic [MODEL_W-1:0] phase_model [0:PHASES-1];
    int                 p;
    int                 n;
    phase_model = '{MODEL_SHORT, MODEL_MEDIUM, MODEL_LONG, MODEL_UNUSED,
                    MODEL_LONG, MODEL_SHORT, MODEL_MEDIUM, MODEL_LONG};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: range edges, breakpoints and segment ends
    push_distance(10'd0); push_distance(10'd1); push_distance(10'd2); push_distance(10'd3);
    push_distance(10'd9); push_distance(10'd80); push_distance(10'd81);
    push_distance(10'd599); push_distance(10'd600); push_distance(10'd1023);
    push_distance(10'd512);
    set_model(MODEL_MEDIUM);
    push_distance(10'd10); push_distance(10'd15); push_distance(10'd150);
    push_distance(10'd151); push_distance(10'd599);
    set_model(MODEL_LONG);
    push_distance(10'd10); push_distance(10'd37); push_distance(10'd55);
    push_distance(10'd549); push_distance(10'd550); push_distance(10'd599);
    push_distance(10'd600);
    set_model(MODEL_UNUSED);
    push_distance(10'd300); push_distance(10'd1);

    for (p = 0; p < PHASES; p++) begin
      set_model(phase_model[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (n = 0; n < RAND_ITEMS / PHASES; n++) push_distance(pick_distance());
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY * 2) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/irdc_pkg.sv
design/irdc_seg_find.sv
design/irdc_num_calc.sv
design/irdc_divider.sv
design/ir_distance_curve_interp.sv
test/irdc_voltage_checker.sv
test/tb_ir_distance_curve_interp.sv
